@@ design/e2e_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2e_pkg
// Shared widths, constants and the arctangent step table for the
// equatorial to ecliptic conversion pipeline.
// ----------------------------------------------------------------------------
package e2e_pkg;

    // Internal angles are signed, 2^-24 degree.
    localparam int IFRAC = 24;
    localparam int ANG_W = 34;
    // Direction terms from the rotation CORDIC, signed Q30.
    localparam int DIR_W = 33;
    // Vectoring CORDIC datapath width, signed Q30 with headroom for the gain.
    localparam int VEC_W = 34;
    localparam int PROD_W = 66;

    localparam logic signed [ANG_W-1:0] DEG_45 = ANG_W'(64'd45 << IFRAC);
    localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(64'd180 << IFRAC);
    localparam logic signed [ANG_W-1:0] DEG_100 = ANG_W'(64'd100 << IFRAC);

    // CORDIC gain correction, 0.6072529350 in Q30.
    localparam logic signed [DIR_W-1:0] GAIN_Q30 = DIR_W'(652032874);
    localparam logic [63:0] RAD2DEG_Q20 = 64'd60078979;

    localparam logic [16:0] OBLIQUITY_RESET = 17'd24002;

    // Arctangent of 2^-i in 2^-24 degree, from the shift-based series in
    // Q60 radians truncated to Q36 and scaled by 180/pi. Elaboration only.
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] deg;
        int          sh;
        pos = 64'd0;
        neg = 64'd0;
        if (i == 0) begin
            return DEG_45;
        end
        for (int k = 0; k < 32; k++) begin
            sh = i * (2 * k + 1);
            if (sh <= 60) begin
                term = (64'd1 << (60 - sh)) / 64'(2 * k + 1);
                if ((k % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
        end
        r = (pos - neg) >> 24;
        deg = (r * RAD2DEG_Q20 + (64'd1 << 31)) >> 32;
        return ANG_W'(deg);
    endfunction

endpackage
`default_nettype wire

@@ design/e2e_rot_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2e_rot_cordic
// Pipelined rotation-mode CORDIC giving sine and cosine of an angle that
// is already folded into -90..+90 degrees, with a half-turn flip applied
// at the output register. One register stage per iteration.
// ----------------------------------------------------------------------------
module e2e_rot_cordic #(
    parameter int STAGES = 20
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic                               valid_i,
    input  wire logic signed [e2e_pkg::ANG_W-1:0]   z_i,
    input  wire logic                               flip_i,
    output logic                                    valid_o,
    output logic signed [e2e_pkg::DIR_W-1:0]        sin_o,
    output logic signed [e2e_pkg::DIR_W-1:0]        cos_o
);
    import e2e_pkg::*;

    logic                    valid_reg [0:STAGES];
    logic                    flip_reg  [0:STAGES];
    logic signed [DIR_W-1:0] x_reg     [0:STAGES];
    logic signed [DIR_W-1:0] y_reg     [0:STAGES];
    logic signed [ANG_W-1:0] z_reg     [0:STAGES];

    logic                    out_valid_reg;
    logic signed [DIR_W-1:0] sin_reg;
    logic signed [DIR_W-1:0] cos_reg;

    // Stage zero is the input itself.
    always_comb begin
        valid_reg[0] = valid_i;
        flip_reg[0]  = flip_i;
        x_reg[0]     = GAIN_Q30;
        y_reg[0]     = '0;
        z_reg[0]     = z_i;
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic signed [ANG_W-1:0] AT = atan_step(g);
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] x_next;
        logic signed [DIR_W-1:0] y_next;
        logic signed [ANG_W-1:0] z_next;

        always_comb begin
            dx = y_reg[g] >>> g;
            dy = x_reg[g] >>> g;
            if (z_reg[g] >= 0) begin
                x_next = x_reg[g] - dx;
                y_next = y_reg[g] + dy;
                z_next = z_reg[g] - AT;
            end else begin
                x_next = x_reg[g] + dx;
                y_next = y_reg[g] - dy;
                z_next = z_reg[g] + AT;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g+1] <= 1'b0;
            end else if (en) begin
                valid_reg[g+1] <= valid_reg[g];
            end
            if (en) begin
                flip_reg[g+1] <= flip_reg[g];
                x_reg[g+1]    <= x_next;
                y_reg[g+1]    <= y_next;
                z_reg[g+1]    <= z_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[STAGES];
        end
        if (en) begin
            sin_reg <= flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
            cos_reg <= flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
        end
    end

    assign valid_o = out_valid_reg;
    assign sin_o   = sin_reg;
    assign cos_o   = cos_reg;

endmodule
`default_nettype wire

@@ design/e2e_vec_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2e_vec_cordic
// Pipelined vectoring-mode CORDIC: full-circle atan2 and gain-scaled
// length, with a side word carried along in step with the item.
// ----------------------------------------------------------------------------
module e2e_vec_cordic #(
    parameter int STAGES = 20,
    parameter int SIDE_W = 34
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic                               valid_i,
    input  wire logic signed [e2e_pkg::VEC_W-1:0]   x_i,
    input  wire logic signed [e2e_pkg::VEC_W-1:0]   y_i,
    input  wire logic        [SIDE_W-1:0]           side_i,
    output logic                                    valid_o,
    output logic signed [e2e_pkg::ANG_W-1:0]        ang_o,
    output logic signed [e2e_pkg::VEC_W-1:0]        mag_o,
    output logic        [SIDE_W-1:0]                side_o
);
    import e2e_pkg::*;

    logic                    valid_reg [0:STAGES];
    logic                    zero_reg  [0:STAGES];
    logic [SIDE_W-1:0]       side_reg  [0:STAGES];
    logic signed [VEC_W-1:0] x_reg     [0:STAGES];
    logic signed [VEC_W-1:0] y_reg     [0:STAGES];
    logic signed [ANG_W-1:0] z_reg     [0:STAGES];

    logic                    out_valid_reg;
    logic signed [ANG_W-1:0] ang_reg;
    logic signed [VEC_W-1:0] mag_reg;
    logic [SIDE_W-1:0]       out_side_reg;

    // Vectors in the left half-plane are turned by a half circle first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= valid_i;
        end
        if (en) begin
            zero_reg[0] <= (x_i == '0) && (y_i == '0);
            side_reg[0] <= side_i;
            if (x_i < 0) begin
                x_reg[0] <= -x_i;
                y_reg[0] <= -y_i;
                z_reg[0] <= (y_i >= 0) ? DEG_180 : -DEG_180;
            end else begin
                x_reg[0] <= x_i;
                y_reg[0] <= y_i;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic signed [ANG_W-1:0] AT = atan_step(g);
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic signed [VEC_W-1:0] x_next;
        logic signed [VEC_W-1:0] y_next;
        logic signed [ANG_W-1:0] z_next;

        always_comb begin
            dx = y_reg[g] >>> g;
            dy = x_reg[g] >>> g;
            if (y_reg[g] >= 0) begin
                x_next = x_reg[g] + dx;
                y_next = y_reg[g] - dy;
                z_next = z_reg[g] + AT;
            end else begin
                x_next = x_reg[g] - dx;
                y_next = y_reg[g] + dy;
                z_next = z_reg[g] - AT;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g+1] <= 1'b0;
            end else if (en) begin
                valid_reg[g+1] <= valid_reg[g];
            end
            if (en) begin
                zero_reg[g+1] <= zero_reg[g];
                side_reg[g+1] <= side_reg[g];
                x_reg[g+1]    <= x_next;
                y_reg[g+1]    <= y_next;
                z_reg[g+1]    <= z_next;
            end
        end
    end

    // A zero vector has no direction: angle and length both read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[STAGES];
        end
        if (en) begin
            ang_reg      <= zero_reg[STAGES] ? '0 : z_reg[STAGES];
            mag_reg      <= zero_reg[STAGES] ? '0 : x_reg[STAGES];
            out_side_reg <= side_reg[STAGES];
        end
    end

    assign valid_o = out_valid_reg;
    assign ang_o   = ang_reg;
    assign mag_o   = mag_reg;
    assign side_o  = out_side_reg;

endmodule
`default_nettype wire

@@ design/equatorial_to_ecliptic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// equatorial_to_ecliptic
// Converts a star's right ascension and declination into ecliptic latitude
// and longitude by a rotation about the x axis by the obliquity.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the result side does not stall,
// and returns one word per input word, in order. The stages, in order: two
// input stages, three rotation CORDICs side by side (CORDIC_STAGES + 1),
// three product stages, the longitude vectoring CORDIC (CORDIC_STAGES + 2),
// one gain-correction stage, the latitude vectoring CORDIC
// (CORDIC_STAGES + 2) and the output register. The whole pipeline
// advances together whenever the output register is empty or being taken,
// so a stall on the result side holds every stage in place. The obliquity
// register may be written at any time through the cfg port, but should only
// be changed while no words are in flight.
module equatorial_to_ecliptic #(
    parameter int ANGLE_FRAC_BITS = 10,
    parameter int CORDIC_STAGES   = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Obliquity register write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [16:0] cfg_data,
    // Input words: [18:0] right_ascension, [36:19] declination, [39:37] zero.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // Result words: [17:0] ecliptic_latitude, [36:18] ecliptic_longitude,
    // [39:37] zero.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata
);
    import e2e_pkg::*;

    // External angle reduction runs in external units.
    localparam int RED_W    = 27;
    localparam int UP_SHIFT = IFRAC - ANGLE_FRAC_BITS;
    localparam logic signed [RED_W-1:0] FULL_EXT = RED_W'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [RED_W-1:0] HALF_EXT = RED_W'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [RED_W-1:0] QUAR_EXT = RED_W'(90 << ANGLE_FRAC_BITS);

    function automatic int calc_red_j();
        int j;
        j = 0;
        while ((64'(360 << ANGLE_FRAC_BITS) << j) < 64'd524288) begin
            j++;
        end
        return j;
    endfunction

    localparam int RED_J = calc_red_j();
    localparam logic signed [ANG_W-1:0] LAT_LIM = ANG_W'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] LON_LIM = ANG_W'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] RND_HALF = ANG_W'(64'd1 << (UP_SHIFT - 1));

    // Folds an external angle into -90..+90 degrees plus a half-turn flag,
    // and scales it to internal units. Bit ANG_W of the result is the flag.
    function automatic logic [ANG_W:0] fold_angle(input logic signed [RED_W-1:0] v);
        logic signed [RED_W-1:0] m;
        logic                    flip;
        m = v;
        flip = 1'b0;
        if (m < 0) begin
            m = m + (FULL_EXT <<< RED_J);
        end
        for (int j = RED_J; j >= 0; j--) begin
            if (m >= (FULL_EXT <<< j)) begin
                m = m - (FULL_EXT <<< j);
            end
        end
        if (m >= HALF_EXT) begin
            m = m - FULL_EXT;
        end
        if (m > QUAR_EXT) begin
            m = m - HALF_EXT;
            flip = 1'b1;
        end else if (m < -QUAR_EXT) begin
            m = m + HALF_EXT;
            flip = 1'b1;
        end
        return {flip, ANG_W'(m) <<< UP_SHIFT};
    endfunction

    // Pipeline advance: everything moves when the output can take a word.
    logic en;
    logic m_valid_reg;
    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Obliquity register.
    logic [16:0] obliquity_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obliquity_reg <= OBLIQUITY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            obliquity_reg <= cfg_data;
        end
    end

    // Stage 0: input capture.
    logic               s0_valid_reg;
    logic [18:0]        ra_reg;
    logic signed [17:0] dec_reg;
    logic [16:0]        eps_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
        end
        if (en) begin
            ra_reg  <= s_tdata[18:0];
            dec_reg <= s_tdata[36:19];
            eps_reg <= obliquity_reg;
        end
    end

    // Stage 1: fold all three angles into the CORDIC range.
    logic [ANG_W:0] ra_fold;
    logic [ANG_W:0] dec_fold;
    logic [ANG_W:0] eps_fold;
    assign ra_fold  = fold_angle(RED_W'({1'b0, ra_reg}));
    assign dec_fold = fold_angle(RED_W'(dec_reg));
    assign eps_fold = fold_angle(RED_W'({1'b0, eps_reg}));

    logic                    s1_valid_reg;
    logic [ANG_W:0]          ra_f_reg;
    logic [ANG_W:0]          dec_f_reg;
    logic [ANG_W:0]          eps_f_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s0_valid_reg;
        end
        if (en) begin
            ra_f_reg  <= ra_fold;
            dec_f_reg <= dec_fold;
            eps_f_reg <= eps_fold;
        end
    end

    // Sine and cosine of the three angles, side by side.
    logic                    rot_valid;
    logic signed [DIR_W-1:0] sa, ca, sd, cd, se, ce;

    e2e_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_ra (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s1_valid_reg),
        .z_i(ra_f_reg[ANG_W-1:0]), .flip_i(ra_f_reg[ANG_W]),
        .valid_o(rot_valid), .sin_o(sa), .cos_o(ca)
    );
    e2e_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_dec (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s1_valid_reg),
        .z_i(dec_f_reg[ANG_W-1:0]), .flip_i(dec_f_reg[ANG_W]),
        .valid_o(), .sin_o(sd), .cos_o(cd)
    );
    e2e_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_eps (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s1_valid_reg),
        .z_i(eps_f_reg[ANG_W-1:0]), .flip_i(eps_f_reg[ANG_W]),
        .valid_o(), .sin_o(se), .cos_o(ce)
    );

    // Product stage 1: first-level products, kept at full Q60 width.
    logic                     p1_valid_reg;
    logic signed [PROD_W-1:0] p1_t_reg;
    logic signed [PROD_W-1:0] p1_x_reg;
    logic signed [PROD_W-1:0] p1_sesd_reg;
    logic signed [PROD_W-1:0] p1_cesd_reg;
    logic signed [DIR_W-1:0]  p1_se_reg;
    logic signed [DIR_W-1:0]  p1_ce_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= rot_valid;
        end
        if (en) begin
            p1_t_reg    <= PROD_W'(sa) * PROD_W'(cd);
            p1_x_reg    <= PROD_W'(ca) * PROD_W'(cd);
            p1_sesd_reg <= PROD_W'(se) * PROD_W'(sd);
            p1_cesd_reg <= PROD_W'(ce) * PROD_W'(sd);
            p1_se_reg   <= se;
            p1_ce_reg   <= ce;
        end
    end

    // Product stage 2: the obliquity terms of sin(ra) cos(dec).
    logic signed [DIR_W-1:0] t_q30;
    assign t_q30 = DIR_W'(p1_t_reg >>> 30);

    logic                     p2_valid_reg;
    logic signed [PROD_W-1:0] p2_cet_reg;
    logic signed [PROD_W-1:0] p2_set_reg;
    logic signed [PROD_W-1:0] p2_sesd_reg;
    logic signed [PROD_W-1:0] p2_cesd_reg;
    logic signed [VEC_W-1:0]  p2_x_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
        if (en) begin
            p2_cet_reg  <= PROD_W'(p1_ce_reg) * PROD_W'(t_q30);
            p2_set_reg  <= PROD_W'(p1_se_reg) * PROD_W'(t_q30);
            p2_sesd_reg <= p1_sesd_reg;
            p2_cesd_reg <= p1_cesd_reg;
            p2_x_reg    <= VEC_W'(p1_x_reg >>> 30);
        end
    end

    // Product stage 3: rotated y and z terms.
    logic signed [PROD_W-1:0] y_sum;
    logic signed [PROD_W-1:0] z_sum;
    assign y_sum = p2_sesd_reg + p2_cet_reg;
    assign z_sum = p2_cesd_reg - p2_set_reg;

    logic                    p3_valid_reg;
    logic signed [VEC_W-1:0] p3_x_reg;
    logic signed [VEC_W-1:0] p3_y_reg;
    logic signed [VEC_W-1:0] p3_z_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
        if (en) begin
            p3_x_reg <= p2_x_reg;
            p3_y_reg <= VEC_W'(y_sum >>> 30);
            p3_z_reg <= VEC_W'(z_sum >>> 30);
        end
    end

    // Longitude: atan2(y, x); the z term rides along for the latitude.
    logic                    lon_valid;
    logic signed [ANG_W-1:0] lon_ang;
    logic signed [VEC_W-1:0] lon_mag;
    logic [VEC_W-1:0]        lon_side;

    e2e_vec_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(VEC_W)) u_vec_lon (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(p3_valid_reg),
        .x_i(p3_x_reg), .y_i(p3_y_reg), .side_i(p3_z_reg),
        .valid_o(lon_valid), .ang_o(lon_ang), .mag_o(lon_mag), .side_o(lon_side)
    );

    // Gain correction of the equatorial-plane length.
    logic signed [PROD_W-1:0] r_full;
    assign r_full = PROD_W'(lon_mag) * PROD_W'(GAIN_Q30);

    logic                    mg_valid_reg;
    logic signed [VEC_W-1:0] mg_r_reg;
    logic signed [VEC_W-1:0] mg_z_reg;
    logic signed [ANG_W-1:0] mg_lon_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mg_valid_reg <= 1'b0;
        end else if (en) begin
            mg_valid_reg <= lon_valid;
        end
        if (en) begin
            mg_r_reg   <= VEC_W'(r_full >>> 30);
            mg_z_reg   <= lon_side;
            mg_lon_reg <= lon_ang;
        end
    end

    // Latitude: atan2(z, length), the longitude rides along.
    logic                    lat_valid;
    logic signed [ANG_W-1:0] lat_ang;
    logic [ANG_W-1:0]        lat_side;

    e2e_vec_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(ANG_W)) u_vec_lat (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(mg_valid_reg),
        .x_i(mg_r_reg), .y_i(mg_z_reg), .side_i(mg_lon_reg),
        .valid_o(lat_valid), .ang_o(lat_ang), .mag_o(), .side_o(lat_side)
    );

    // Output: round half up to external units, then clamp.
    logic signed [ANG_W-1:0] lat_rnd;
    logic signed [ANG_W-1:0] lon_rnd;
    logic signed [ANG_W-1:0] lat_clamp;
    logic signed [ANG_W-1:0] lon_clamp;
    always_comb begin
        lat_rnd = (lat_ang + RND_HALF) >>> UP_SHIFT;
        lon_rnd = ($signed(lat_side) + RND_HALF) >>> UP_SHIFT;
        lat_clamp = lat_rnd;
        if (lat_rnd > LAT_LIM) begin
            lat_clamp = LAT_LIM;
        end else if (lat_rnd < -LAT_LIM) begin
            lat_clamp = -LAT_LIM;
        end
        lon_clamp = lon_rnd;
        if (lon_rnd > LON_LIM) begin
            lon_clamp = LON_LIM;
        end else if (lon_rnd < -LON_LIM) begin
            lon_clamp = -LON_LIM;
        end
    end

    logic [17:0] lat_out_reg;
    logic [18:0] lon_out_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= lat_valid;
        end
        if (en) begin
            lat_out_reg <= lat_clamp[17:0];
            lon_out_reg <= lon_clamp[18:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, lon_out_reg, lat_out_reg};

`ifndef NO_ASSERTIONS
    // A stall must freeze the middle of the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(p2_valid_reg) && $stable(p2_cet_reg))
        else $error("pipeline moved during a stall");

    // The latitude vector has a non-negative x term, so its angle stays
    // within the reach of a right-half-plane CORDIC.
    assert property (@(posedge aclk) disable iff (!aresetn)
        lat_valid |-> (lat_ang <= DEG_100) && (lat_ang >= -DEG_100))
        else $error("latitude angle out of range");
`endif

endmodule
`default_nettype wire
